/* hw/rtl/rrc_pkg.sv */
package rrc_pkg;

  localparam int DIST_W  = 10;
  localparam int TEMP_W  = 12;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 3;
  localparam int STAT_W  = 3;
  localparam int CMD_W   = 2;
  localparam int MODE_W  = 2;
  localparam int SEL_W   = 2;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MODE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELAY  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AWAY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;

  localparam logic [SEL_W-1:0] SEL_RELAY1 = 2'd1;
  localparam logic [SEL_W-1:0] SEL_RELAY2 = 2'd2;

  localparam logic [STAT_W-1:0] ST_BOOT    = 3'd0;
  localparam logic [STAT_W-1:0] ST_MONITOR = 3'd1;
  localparam logic [STAT_W-1:0] ST_ALERT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_MANUAL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FAULT   = 3'd4;

  localparam logic [2:0] REG_OCC_DIST   = 3'd0;
  localparam logic [2:0] REG_TIMEOUT    = 3'd1;
  localparam logic [2:0] REG_ALERT_ON   = 3'd2;
  localparam logic [2:0] REG_ALERT_OFF  = 3'd3;
  localparam logic [2:0] REG_ACTIVE_LOW = 3'd4;

  localparam logic [CNT_W-1:0] FAIL_LIMIT = 3'd5;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 3'd7;

  localparam logic [DIST_W-1:0]        RST_OCC_DIST  = 10'd50;
  localparam logic [TIME_W-1:0]        RST_TIMEOUT   = 32'd30000;
  localparam logic signed [TEMP_W-1:0] RST_ALERT_ON  = 12'sd300;
  localparam logic signed [TEMP_W-1:0] RST_ALERT_OFF = 12'sd280;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic                     dht_ok;
    logic                     distance_ok;
    logic [DIST_W-1:0]        distance_cm;
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic                     light_dark;
    logic [TIME_W-1:0]        now_ms;
    logic [MODE_W-1:0]        new_mode;
    logic [SEL_W-1:0]         relay_select;
    logic                     relay_value;
  } in_word_t;

  typedef struct packed {
    logic              relay1_on;
    logic              relay2_on;
    logic              relay1_level;
    logic              relay2_level;
    logic [STAT_W-1:0] room_status;
    logic [MODE_W-1:0] mode_now;
    logic              occupied;
    logic              temp_alert;
    logic              dht_fault;
    logic              sonar_fault;
    logic              accepted;
  } out_word_t;

endpackage

/* hw/rtl/rrc_if.sv */
interface rrc_in_if;
  logic                             valid;
  logic                             ready;
  logic [rrc_pkg::CMD_W-1:0]        command;
  logic                             dht_ok;
  logic                             distance_ok;
  logic [rrc_pkg::DIST_W-1:0]       distance_cm;
  logic signed [rrc_pkg::TEMP_W-1:0] temperature_tenths;
  logic                             light_dark;
  logic [rrc_pkg::TIME_W-1:0]       now_ms;
  logic [rrc_pkg::MODE_W-1:0]       new_mode;
  logic [rrc_pkg::SEL_W-1:0]        relay_select;
  logic                             relay_value;

  modport source (
    output valid, command, dht_ok, distance_ok, distance_cm, temperature_tenths,
           light_dark, now_ms, new_mode, relay_select, relay_value,
    input  ready
  );
  modport sink (
    input  valid, command, dht_ok, distance_ok, distance_cm, temperature_tenths,
           light_dark, now_ms, new_mode, relay_select, relay_value,
    output ready
  );
endinterface

interface rrc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        relay1_on;
  logic                        relay2_on;
  logic                        relay1_level;
  logic                        relay2_level;
  logic [rrc_pkg::STAT_W-1:0]  room_status;
  logic [rrc_pkg::MODE_W-1:0]  mode_now;
  logic                        occupied;
  logic                        temp_alert;
  logic                        dht_fault;
  logic                        sonar_fault;
  logic                        accepted;

  modport source (
    output valid, relay1_on, relay2_on, relay1_level, relay2_level, room_status,
           mode_now, occupied, temp_alert, dht_fault, sonar_fault, accepted,
    input  ready
  );
  modport sink (
    input  valid, relay1_on, relay2_on, relay1_level, relay2_level, room_status,
           mode_now, occupied, temp_alert, dht_fault, sonar_fault, accepted,
    output ready
  );
endinterface

/* hw/rtl/room_relay_controller.sv */
// Room relay controller. Takes one word per clock on the input channel
// (sensor sample, mode change or manual relay set) while the result side keeps
// up, and returns exactly one result word for each, held until the result
// side is ready: the word is captured in an input register, and once the
// result register is free a single pass of compare and counter logic updates
// the controller state and loads the result register. Back to back words see
// each other's state updates, so the sustained rate is one word per cycle while
// the result side is ready; the result register lets a new word enter while a
// finished result waits. Configuration registers sit on the APB port at byte
// address 4*index and must only be written while no word is in flight.
module room_relay_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  rrc_in_if.sink                        in_if,
  rrc_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrc_pkg::PADDR_W-1:0]   paddr,
  input  logic [rrc_pkg::PDATA_W-1:0]   pwdata,
  output logic [rrc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // configuration
  logic [rrc_pkg::DIST_W-1:0]        occ_dist_r;
  logic [rrc_pkg::TIME_W-1:0]        timeout_r;
  logic signed [rrc_pkg::TEMP_W-1:0] alert_on_r;
  logic signed [rrc_pkg::TEMP_W-1:0] alert_off_r;
  logic                              active_low_r;
  logic                              cfg_wr;
  logic [2:0]                        cfg_idx;

  // controller state
  logic [rrc_pkg::CNT_W-1:0]  dht_cnt_r, dht_cnt_nxt;
  logic [rrc_pkg::CNT_W-1:0]  sonar_cnt_r, sonar_cnt_nxt;
  logic                       alert_r, alert_nxt;
  logic [rrc_pkg::TIME_W-1:0] last_seen_r, last_seen_nxt;
  logic                       seen_r, seen_nxt;
  logic [rrc_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                       relay1_r, relay1_nxt;
  logic                       relay2_r, relay2_nxt;
  logic [rrc_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                       occ_r, occ_nxt;
  logic                       acc;

  // pipeline
  rrc_pkg::in_word_t  s1_r;
  logic               s1_valid_r;
  rrc_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r;
  logic               out_free;
  logic               s2_go;
  logic               in_ready;

  // sample helpers
  logic                       inst;
  logic                       fault;
  logic [rrc_pkg::TIME_W-1:0] elapsed;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[rrc_pkg::PADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      rrc_pkg::REG_OCC_DIST:   prdata = {{(rrc_pkg::PDATA_W-rrc_pkg::DIST_W){1'b0}}, occ_dist_r};
      rrc_pkg::REG_TIMEOUT:    prdata = timeout_r;
      rrc_pkg::REG_ALERT_ON:
        prdata = {{(rrc_pkg::PDATA_W-rrc_pkg::TEMP_W){alert_on_r[rrc_pkg::TEMP_W-1]}},
                  alert_on_r};
      rrc_pkg::REG_ALERT_OFF:
        prdata = {{(rrc_pkg::PDATA_W-rrc_pkg::TEMP_W){alert_off_r[rrc_pkg::TEMP_W-1]}},
                  alert_off_r};
      rrc_pkg::REG_ACTIVE_LOW: prdata = {{(rrc_pkg::PDATA_W-1){1'b0}}, active_low_r};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_dist_r   <= rrc_pkg::RST_OCC_DIST;
      timeout_r    <= rrc_pkg::RST_TIMEOUT;
      alert_on_r   <= rrc_pkg::RST_ALERT_ON;
      alert_off_r  <= rrc_pkg::RST_ALERT_OFF;
      active_low_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rrc_pkg::REG_OCC_DIST:   occ_dist_r   <= pwdata[rrc_pkg::DIST_W-1:0];
        rrc_pkg::REG_TIMEOUT:    timeout_r    <= pwdata[rrc_pkg::TIME_W-1:0];
        rrc_pkg::REG_ALERT_ON:   alert_on_r   <= pwdata[rrc_pkg::TEMP_W-1:0];
        rrc_pkg::REG_ALERT_OFF:  alert_off_r  <= pwdata[rrc_pkg::TEMP_W-1:0];
        rrc_pkg::REG_ACTIVE_LOW: active_low_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free    = ~out_valid_r | out_if.ready;
  assign s2_go       = s1_valid_r & out_free;
  assign in_ready    = ~s1_valid_r | out_free;
  assign in_if.ready = in_ready;

  assign inst    = s1_r.distance_ok && (s1_r.distance_cm != '0) &&
                   (s1_r.distance_cm <= occ_dist_r);
  assign elapsed = s1_r.now_ms - last_seen_r;

  always_comb begin
    dht_cnt_nxt   = dht_cnt_r;
    sonar_cnt_nxt = sonar_cnt_r;
    alert_nxt     = alert_r;
    last_seen_nxt = last_seen_r;
    seen_nxt      = seen_r;
    mode_nxt      = mode_r;
    relay1_nxt    = relay1_r;
    relay2_nxt    = relay2_r;
    status_nxt    = status_r;
    occ_nxt       = occ_r;
    acc           = 1'b1;
    fault         = 1'b0;
    case (s1_r.command)
      rrc_pkg::CMD_SAMPLE: begin
        if (s1_r.dht_ok) begin
          dht_cnt_nxt = '0;
        end else if (dht_cnt_r != rrc_pkg::COUNT_MAX) begin
          dht_cnt_nxt = dht_cnt_r + 1'b1;
        end
        if (s1_r.distance_ok) begin
          sonar_cnt_nxt = '0;
        end else if (sonar_cnt_r != rrc_pkg::COUNT_MAX) begin
          sonar_cnt_nxt = sonar_cnt_r + 1'b1;
        end
        fault = (dht_cnt_nxt >= rrc_pkg::FAIL_LIMIT) ||
                (sonar_cnt_nxt >= rrc_pkg::FAIL_LIMIT);

        occ_nxt = inst | (seen_r & (elapsed < timeout_r));
        if (inst) begin
          last_seen_nxt = s1_r.now_ms;
          seen_nxt      = 1'b1;
        end

        if (s1_r.dht_ok) begin
          if (s1_r.temperature_tenths >= alert_on_r) begin
            alert_nxt = 1'b1;
          end else if (s1_r.temperature_tenths <= alert_off_r) begin
            alert_nxt = 1'b0;
          end
        end

        if (fault) begin
          status_nxt = rrc_pkg::ST_FAULT;
          relay1_nxt = 1'b0;
          relay2_nxt = 1'b0;
        end else begin
          case (mode_r)
            rrc_pkg::MODE_MANUAL: status_nxt = rrc_pkg::ST_MANUAL;
            rrc_pkg::MODE_AWAY: begin
              relay1_nxt = 1'b0;
              relay2_nxt = inst;
              status_nxt = inst ? rrc_pkg::ST_ALERT : rrc_pkg::ST_MONITOR;
            end
            default: begin
              relay1_nxt = s1_r.light_dark & occ_nxt;
              relay2_nxt = alert_nxt;
              status_nxt = alert_nxt ? rrc_pkg::ST_ALERT : rrc_pkg::ST_MONITOR;
            end
          endcase
        end
      end
      rrc_pkg::CMD_MODE: begin
        case (s1_r.new_mode)
          rrc_pkg::MODE_AUTO, rrc_pkg::MODE_AWAY: mode_nxt = s1_r.new_mode;
          rrc_pkg::MODE_MANUAL: begin
            mode_nxt   = rrc_pkg::MODE_MANUAL;
            status_nxt = rrc_pkg::ST_MANUAL;
          end
          default: acc = 1'b0;
        endcase
      end
      rrc_pkg::CMD_RELAY: begin
        case (s1_r.relay_select)
          rrc_pkg::SEL_RELAY1, rrc_pkg::SEL_RELAY2: begin
            mode_nxt   = rrc_pkg::MODE_MANUAL;
            status_nxt = rrc_pkg::ST_MANUAL;
            if (s1_r.relay_select == rrc_pkg::SEL_RELAY1) begin
              relay1_nxt = s1_r.relay_value;
            end else begin
              relay2_nxt = s1_r.relay_value;
            end
          end
          default: acc = 1'b0;
        endcase
      end
      default: acc = 1'b0;
    endcase

    out_nxt.relay1_on    = relay1_nxt;
    out_nxt.relay2_on    = relay2_nxt;
    out_nxt.relay1_level = relay1_nxt ^ active_low_r;
    out_nxt.relay2_level = relay2_nxt ^ active_low_r;
    out_nxt.room_status  = status_nxt;
    out_nxt.mode_now     = mode_nxt;
    out_nxt.occupied     = occ_nxt;
    out_nxt.temp_alert   = alert_nxt;
    out_nxt.dht_fault    = dht_cnt_nxt >= rrc_pkg::FAIL_LIMIT;
    out_nxt.sonar_fault  = sonar_cnt_nxt >= rrc_pkg::FAIL_LIMIT;
    out_nxt.accepted     = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dht_cnt_r   <= '0;
      sonar_cnt_r <= '0;
      alert_r     <= 1'b0;
      last_seen_r <= '0;
      seen_r      <= 1'b0;
      mode_r      <= rrc_pkg::MODE_AUTO;
      relay1_r    <= 1'b0;
      relay2_r    <= 1'b0;
      status_r    <= rrc_pkg::ST_BOOT;
      occ_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_go) begin
        dht_cnt_r   <= dht_cnt_nxt;
        sonar_cnt_r <= sonar_cnt_nxt;
        alert_r     <= alert_nxt;
        last_seen_r <= last_seen_nxt;
        seen_r      <= seen_nxt;
        mode_r      <= mode_nxt;
        relay1_r    <= relay1_nxt;
        relay2_r    <= relay2_nxt;
        status_r    <= status_nxt;
        occ_r       <= occ_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      s1_r.command            <= in_if.command;
      s1_r.dht_ok             <= in_if.dht_ok;
      s1_r.distance_ok        <= in_if.distance_ok;
      s1_r.distance_cm        <= in_if.distance_cm;
      s1_r.temperature_tenths <= in_if.temperature_tenths;
      s1_r.light_dark         <= in_if.light_dark;
      s1_r.now_ms             <= in_if.now_ms;
      s1_r.new_mode           <= in_if.new_mode;
      s1_r.relay_select       <= in_if.relay_select;
      s1_r.relay_value        <= in_if.relay_value;
    end
    if (s2_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.relay1_on    = out_r.relay1_on;
  assign out_if.relay2_on    = out_r.relay2_on;
  assign out_if.relay1_level = out_r.relay1_level;
  assign out_if.relay2_level = out_r.relay2_level;
  assign out_if.room_status  = out_r.room_status;
  assign out_if.mode_now     = out_r.mode_now;
  assign out_if.occupied     = out_r.occupied;
  assign out_if.temp_alert   = out_r.temp_alert;
  assign out_if.dht_fault    = out_r.dht_fault;
  assign out_if.sonar_fault  = out_r.sonar_fault;
  assign out_if.accepted     = out_r.accepted;

endmodule
